// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the data-processing execute block.
// Files that check their own logic include this header by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define A64_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be seen outside reset.
`define A64_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define A64_ASSERT(lbl, clk, rst, prop, msg)
`define A64_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ----- rtl/a64dp_pkg.sv -----
// Types, codes and helpers for the AArch64 data-processing execute block.
// No dependencies; the front, queue, back and top RTL files refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package a64dp_pkg;

  // instruction bit positions
  localparam int unsigned M_BIT           = 28;
  localparam int unsigned OPR_BIT         = 24;
  localparam int unsigned N_BIT           = 21;
  localparam int unsigned SF_BIT          = 31;
  localparam int unsigned MSUB_BIT        = 15;

  typedef enum logic [1:0] {
    CLS_LOGIC = 2'd0,
    CLS_ARITH = 2'd1,
    CLS_MUL   = 2'd2
  } op_class_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_t;

  // logical opc codes
  localparam logic [1:0] LOP_AND  = 2'd0;
  localparam logic [1:0] LOP_ORR  = 2'd1;
  localparam logic [1:0] LOP_EOR  = 2'd2;
  localparam logic [1:0] LOP_ANDS = 2'd3;

  // arithmetic opc bits
  localparam int unsigned AOPC_SUB_BIT  = 1;
  localparam int unsigned AOPC_SETF_BIT = 0;

  // decoded item, as held between front and back
  typedef struct packed {
    logic [4:0]  rd;
    logic        wide;
    op_class_t   cls;
    logic [1:0]  opc;
    shift_t      stype;
    logic [5:0]  amt;
    logic        nbit;
    logic        msub;
    logic [63:0] rn;
    logic [63:0] rm;
    logic [63:0] ra;
  } dec_item_t;

  function automatic logic [63:0] width_mask(logic wide, logic [63:0] v);
    return wide ? v : {32'b0, v[31:0]};
  endfunction

  function automatic logic sign_of(logic wide, logic [63:0] v);
    return wide ? v[63] : v[31];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/a64dp_if.sv -----
// Valid/ready channel interfaces for the execute block: instruction in, result out.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
interface a64dp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;
  logic [63:0] first_operand;
  logic [63:0] second_operand;
  logic [63:0] addend_operand;

  modport source (output valid, output instruction_word, output first_operand,
                  output second_operand, output addend_operand, input ready);
  modport sink   (input valid, input instruction_word, input first_operand,
                  input second_operand, input addend_operand, output ready);
endinterface

interface a64dp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  dest_index;
  logic [63:0] result_value;
  logic        write_enable;
  logic        flags_update;
  logic [3:0]  new_flags;

  modport source (output valid, output dest_index, output result_value,
                  output write_enable, output flags_update, output new_flags,
                  input ready);
  modport sink   (input valid, input dest_index, input result_value,
                  input write_enable, input flags_update, input new_flags,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/a64dp_queue.sv -----
// Small FIFO of decoded items between front and back.
// Depends on a64dp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module a64dp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        push,
  input  wire a64dp_pkg::dec_item_t  push_item,
  output logic                       push_ready,
  output logic                       pop_valid,
  output a64dp_pkg::dec_item_t       pop_item,
  input  wire                        pop
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  a64dp_pkg::dec_item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `A64_ASSERT(q_count_range, clk, rst, count <= FULL, "queue count beyond depth")
  `A64_ASSERT(q_count_up, clk, rst,
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1), "count did not rise on push")
  `A64_NEVER(q_pop_empty, clk, rst, pop && !pop_valid, "pop from empty queue")

endmodule
`default_nettype wire

// ----- rtl/a64dp_front.sv -----
// Front end: accepts instruction items, decodes class, width and shift, masks operands.
// Depends on a64dp_pkg and the channel interfaces in a64dp_if.sv.
`timescale 1ns / 1ps
`default_nettype none
module a64dp_front (
  input  wire                   clk,
  input  wire                   rst,
  a64dp_in_if.sink              in_ch,
  output logic                  dec_valid,
  output a64dp_pkg::dec_item_t  dec_item,
  input  wire                   dec_ready
);
  a64dp_pkg::dec_item_t item_next;
  logic [31:0]          ins;
  logic                 wide;

  assign ins   = in_ch.instruction_word;
  assign wide  = ins[a64dp_pkg::SF_BIT];
  assign in_ch.ready = !dec_valid || dec_ready;

  always_comb begin
    item_next.rd    = ins[4:0];
    item_next.wide  = wide;
    if (ins[a64dp_pkg::M_BIT]) begin
      item_next.cls = a64dp_pkg::CLS_MUL;
    end else if (ins[a64dp_pkg::OPR_BIT]) begin
      item_next.cls = a64dp_pkg::CLS_ARITH;
    end else begin
      item_next.cls = a64dp_pkg::CLS_LOGIC;
    end
    item_next.opc   = ins[30:29];
    item_next.stype = a64dp_pkg::shift_t'(ins[23:22]);
    // narrow forms use only the low five bits of the amount
    item_next.amt   = wide ? ins[15:10] : {1'b0, ins[14:10]};
    item_next.nbit  = ins[a64dp_pkg::N_BIT];
    item_next.msub  = ins[a64dp_pkg::MSUB_BIT];
    item_next.rn    = a64dp_pkg::width_mask(wide, in_ch.first_operand);
    item_next.rm    = a64dp_pkg::width_mask(wide, in_ch.second_operand);
    item_next.ra    = a64dp_pkg::width_mask(wide, in_ch.addend_operand);
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      dec_item <= item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (in_ch.ready) begin
      dec_valid <= in_ch.valid;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/a64dp_back.sv -----
// Back end: shifter and split multiplier, then ALU/product, then result register.
// Depends on a64dp_pkg, a64dp_if.sv and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module a64dp_back (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        q_valid,
  input  wire a64dp_pkg::dec_item_t  q_item,
  output logic                       q_pop,
  a64dp_out_if.source                out_ch
);
  typedef struct packed {
    logic [4:0]           rd;
    logic                 wide;
    a64dp_pkg::op_class_t cls;
    logic [1:0]           opc;
    logic                 nbit;
    logic                 msub;
    logic [63:0]          rn;
    logic [63:0]          ra;
    logic [63:0]          op2;
    logic [63:0]          pll;
    logic [31:0]          plh;
    logic [31:0]          phl;
  } s1_t;

  typedef struct packed {
    logic [4:0]  rd;
    logic        wide;
    logic        is_mul;
    logic        msub;
    logic [63:0] ra;
    logic [63:0] prod;
    logic [63:0] res;
    logic        setf;
    logic [3:0]  flags;
  } s2_t;

  s1_t s1, s1_next;
  s2_t s2, s2_next;
  logic v1, v2;
  logic out_ok, rdy2, rdy1;

  // stage one signals
  logic [63:0]  v;
  logic [63:0]  asr_src;
  logic [127:0] rot_wide;
  logic [63:0]  rot_narrow;
  logic [63:0]  shifted;
  logic [63:0]  pll_full;
  logic [63:0]  plh_full;
  logic [63:0]  phl_full;

  // stage two signals
  logic        sub;
  logic [63:0] b;
  logic [64:0] sum;
  logic [63:0] ares;
  logic        carry;
  logic        ovf;
  logic [63:0] lres;
  logic [31:0] cross_sum;

  // result stage signals
  logic [63:0] mres;
  logic [63:0] res_next;

  assign out_ok = !out_ch.valid || out_ch.ready;
  assign rdy2   = !v2 || out_ok;
  assign rdy1   = !v1 || rdy2;
  assign q_pop  = q_valid && rdy1;

  // stage one: shift Rm, 32x32 partial products of Rn*Rm
  always_comb begin
    v          = q_item.rm;
    asr_src    = q_item.wide ? v : {{32{v[31]}}, v[31:0]};
    rot_wide   = {v, v} >> q_item.amt;
    rot_narrow = {v[31:0], v[31:0]} >> q_item.amt;
    case (q_item.stype)
      a64dp_pkg::SH_LSL: shifted = a64dp_pkg::width_mask(q_item.wide, v << q_item.amt);
      a64dp_pkg::SH_LSR: shifted = v >> q_item.amt;
      a64dp_pkg::SH_ASR: shifted = a64dp_pkg::width_mask(q_item.wide,
                                     64'($signed(asr_src) >>> q_item.amt));
      default:           shifted = q_item.wide ? rot_wide[63:0]
                                               : {32'b0, rot_narrow[31:0]};
    endcase
    pll_full = q_item.rn[31:0] * q_item.rm[31:0];
    plh_full = q_item.rn[31:0] * q_item.rm[63:32];
    phl_full = q_item.rn[63:32] * q_item.rm[31:0];

    s1_next.rd   = q_item.rd;
    s1_next.wide = q_item.wide;
    s1_next.cls  = q_item.cls;
    s1_next.opc  = q_item.opc;
    s1_next.nbit = q_item.nbit;
    s1_next.msub = q_item.msub;
    s1_next.rn   = q_item.rn;
    s1_next.ra   = q_item.ra;
    s1_next.op2  = shifted;
    s1_next.pll  = pll_full;
    s1_next.plh  = plh_full[31:0];
    s1_next.phl  = phl_full[31:0];
  end

  // stage two: add/sub with NZCV, logical ops, product assembly
  always_comb begin
    sub   = s1.opc[a64dp_pkg::AOPC_SUB_BIT];
    b     = a64dp_pkg::width_mask(s1.wide,
              ((s1.cls == a64dp_pkg::CLS_ARITH) ? sub : s1.nbit) ? ~s1.op2 : s1.op2);
    sum   = {1'b0, s1.rn} + {1'b0, b} + {64'b0, sub};
    ares  = a64dp_pkg::width_mask(s1.wide, sum[63:0]);
    carry = s1.wide ? sum[64] : sum[32];
    ovf   = a64dp_pkg::sign_of(s1.wide, (s1.rn ^ ares) & (b ^ ares));
    case (s1.opc)
      a64dp_pkg::LOP_ORR: lres = s1.rn | b;
      a64dp_pkg::LOP_EOR: lres = s1.rn ^ b;
      default:            lres = s1.rn & b;
    endcase
    cross_sum = s1.plh + s1.phl;

    s2_next.rd     = s1.rd;
    s2_next.wide   = s1.wide;
    s2_next.is_mul = (s1.cls == a64dp_pkg::CLS_MUL);
    s2_next.msub   = s1.msub;
    s2_next.ra     = s1.ra;
    s2_next.prod   = a64dp_pkg::width_mask(s1.wide, s1.pll + {cross_sum, 32'b0});
    case (s1.cls)
      a64dp_pkg::CLS_ARITH: begin
        s2_next.res   = ares;
        s2_next.setf  = s1.opc[a64dp_pkg::AOPC_SETF_BIT];
        s2_next.flags = {a64dp_pkg::sign_of(s1.wide, ares), ares == '0, carry, ovf};
      end
      a64dp_pkg::CLS_LOGIC: begin
        s2_next.res   = lres;
        s2_next.setf  = (s1.opc == a64dp_pkg::LOP_ANDS);
        s2_next.flags = {a64dp_pkg::sign_of(s1.wide, lres), lres == '0, 2'b00};
      end
      default: begin
        s2_next.res   = '0;
        s2_next.setf  = 1'b0;
        s2_next.flags = 4'b0000;
      end
    endcase
  end

  // result stage: multiply-accumulate, or pass the ALU result through
  always_comb begin
    mres     = a64dp_pkg::width_mask(s2.wide, s2.msub ? s2.ra - s2.prod : s2.ra + s2.prod);
    res_next = s2.is_mul ? mres : s2.res;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1 <= s1_next;
    end
    if (rdy2) begin
      s2 <= s2_next;
    end
    if (out_ok) begin
      out_ch.dest_index   <= s2.rd;
      out_ch.result_value <= res_next;
      out_ch.write_enable <= (s2.rd != 5'd31);
      out_ch.flags_update <= s2.setf;
      out_ch.new_flags    <= s2.setf ? s2.flags : 4'b0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= q_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (out_ok) begin
        out_ch.valid <= v2;
      end
    end
  end

  `A64_ASSERT(b_s2_hold, clk, rst, (v2 && !out_ok) |=> v2, "stage two item lost")
  `A64_ASSERT(b_s1_hold, clk, rst,
    (v1 && !rdy2) |=> (v1 && $stable(s1)), "stage one item changed while stalled")
  `A64_ASSERT(b_flags_clear, clk, rst,
    (out_ch.valid && !out_ch.flags_update) |-> (out_ch.new_flags == 4'b0000), "stray flags")

endmodule
`default_nettype wire

// ----- rtl/aarch64_dp_register_execute.sv -----
// Top level of the AArch64 data-processing (register) execute block.
// Depends on a64dp_pkg, a64dp_if.sv, a64dp_front, a64dp_queue and a64dp_back.
//
//   channel  | dir | payload
//   ---------+-----+--------------------------------------------------------
//   in_ch    | in  | instruction_word, first/second/addend_operand (Rn,Rm,Ra)
//   out_ch   | out | dest_index, result_value, write_enable, flags_update,
//            |     | new_flags
//
// One item per cycle sustained while out_ch is ready. An accepted item passes
// the front decode register, queue, shift/partial-product stage, ALU/product
// stage and the result register, which does the multiply-add, to reach out_ch.
// The 64-bit product is built from three 32x32 multipliers, hence its own stage.
// Reset (rst, synchronous) empties the front register, queue and back stages.
// A stall on out_ch backs up the back stages first; the front keeps taking
// items until the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module aarch64_dp_register_execute #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire          clk,
  input  wire          rst,
  a64dp_in_if.sink     in_ch,
  a64dp_out_if.source  out_ch
);
  // front to queue
  logic                 dec_valid;
  logic                 dec_ready;
  a64dp_pkg::dec_item_t dec_item;

  // queue to back
  logic                 q_valid;
  logic                 q_pop;
  a64dp_pkg::dec_item_t q_item;

  a64dp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .dec_valid (dec_valid),
    .dec_item  (dec_item),
    .dec_ready (dec_ready)
  );

  // decoupling queue; its full flag is registered, so no ready path crosses it
  a64dp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (dec_valid),
    .push_item  (dec_item),
    .push_ready (dec_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  a64dp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for aarch64_dp_register_execute: directed and random items.
// Predicts every result and checks it; needs a64dp_pkg and the channel interfaces.
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int HOLD_CYCLES    = 60;    // long receiver hold-off
  localparam int DRAIN_TAIL     = 8;     // pipeline depth, allow a little over
  localparam int PHASE_ITEMS    = 176;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MSB64    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64    = 64'h7FFF_FFFF_FFFF_FFFF;

  // arithmetic opc values, built from the package bit positions
  localparam logic [1:0] AOP_ADD  = 2'b00;
  localparam logic [1:0] AOP_ADDS = 2'b01 << a64dp_pkg::AOPC_SETF_BIT;
  localparam logic [1:0] AOP_SUB  = 2'b01 << a64dp_pkg::AOPC_SUB_BIT;
  localparam logic [1:0] AOP_SUBS = AOP_SUB | AOP_ADDS;

  // one result item as it leaves the block
  typedef struct packed {
    logic [4:0]  dest;
    logic [63:0] value;
    logic        wen;
    logic        fupd;
    logic [3:0]  nzcv;
  } exec_result_t;

  // Holds the results still owed by the block, oldest first, and checks each
  // one that comes out against them.
  class exec_scoreboard;
    exec_result_t awaited[$];
    int mismatch_count = 0;

    // What the block must produce for one instruction and its operands.
    function exec_result_t exec_outcome(logic [31:0] word, logic [63:0] rn_raw,
                                        logic [63:0] rm_raw, logic [63:0] ra_raw);
      logic               wide;
      logic [63:0]        mask, sign, rn, rm, ra, op2, b, prod, res;
      logic signed [63:0] s64;
      logic signed [31:0] s32;
      logic [31:0]        n32;
      logic [5:0]         amt;
      a64dp_pkg::shift_t  st;
      logic [1:0]         opc;
      logic               carry, ovf, setf;
      logic [3:0]         nzcv;
      exec_result_t       r;
      wide = word[a64dp_pkg::SF_BIT];
      mask = wide ? ALL_ONES : 64'h0000_0000_FFFF_FFFF;
      sign = wide ? MSB64 : 64'h0000_0000_8000_0000;
      rn   = rn_raw & mask;
      rm   = rm_raw & mask;
      ra   = ra_raw & mask;
      opc  = word[30:29];
      st   = a64dp_pkg::shift_t'(word[23:22]);
      // 32-bit forms only honour the low five bits of the amount
      amt  = wide ? word[15:10] : {1'b0, word[14:10]};
      setf = 1'b0;
      nzcv = 4'b0;
      res  = '0;
      if (word[a64dp_pkg::M_BIT]) begin
        // multiply-add/subtract, Rm taken unshifted
        prod = (rn * rm) & mask;
        res  = (word[a64dp_pkg::MSUB_BIT] ? ra - prod : ra + prod) & mask;
      end else begin
        op2 = rm;
        if (amt != 6'd0) begin
          case (st)
            a64dp_pkg::SH_LSL: op2 = (rm << amt) & mask;
            a64dp_pkg::SH_LSR: op2 = rm >> amt;
            a64dp_pkg::SH_ASR: begin
              if (wide) begin
                s64 = rm;
                s64 = s64 >>> amt;
                op2 = s64;
              end else begin
                s32 = rm[31:0];
                s32 = s32 >>> amt;
                op2 = {32'b0, s32};
              end
            end
            a64dp_pkg::SH_ROR: begin
              if (wide) begin
                op2 = (rm >> amt) | (rm << (64 - amt));
              end else begin
                n32 = (rm[31:0] >> amt) | (rm[31:0] << (32 - amt));
                op2 = {32'b0, n32};
              end
            end
          endcase
        end
        if (word[a64dp_pkg::OPR_BIT]) begin
          b     = opc[a64dp_pkg::AOPC_SUB_BIT] ? (~op2 & mask) : op2;
          res   = (rn + b + {63'b0, opc[a64dp_pkg::AOPC_SUB_BIT]}) & mask;
          carry = opc[a64dp_pkg::AOPC_SUB_BIT] ? (rn >= op2) : (res < rn);
          ovf   = ((rn ^ res) & (b ^ res) & sign) != 64'd0;
          setf  = opc[a64dp_pkg::AOPC_SETF_BIT];
          nzcv  = {(res & sign) != 64'd0, res == 64'd0, carry, ovf};
        end else begin
          b = word[a64dp_pkg::N_BIT] ? (~op2 & mask) : op2;
          case (opc)
            a64dp_pkg::LOP_AND:  res = rn & b;
            a64dp_pkg::LOP_ORR:  res = rn | b;
            a64dp_pkg::LOP_EOR:  res = rn ^ b;
            a64dp_pkg::LOP_ANDS: begin
              res  = rn & b;
              setf = 1'b1;
            end
          endcase
          nzcv = {(res & sign) != 64'd0, res == 64'd0, 2'b00};
        end
      end
      r.dest  = word[4:0];
      r.value = res;
      r.wen   = word[4:0] != 5'd31;
      r.fupd  = setf;
      r.nzcv  = setf ? nzcv : 4'b0;
      return r;
    endfunction

    function void note_item(logic [31:0] word, logic [63:0] rn, logic [63:0] rm,
                            logic [63:0] ra);
      awaited.push_back(exec_outcome(word, rn, rm, ra));
    endfunction

    function void flag_mismatch(string what, logic [63:0] want, logic [63:0] seen);
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, seen);
    endfunction

    function void check_result(exec_result_t got);
      exec_result_t want;
      if (awaited.size() == 0) begin
        flag_mismatch("unexpected result, value", 64'd0, got.value);
        return;
      end
      want = awaited.pop_front();
      if (got.dest  != want.dest)  flag_mismatch("dest_index",   want.dest,  got.dest);
      if (got.value != want.value) flag_mismatch("result_value", want.value, got.value);
      if (got.wen   != want.wen)   flag_mismatch("write_enable", want.wen,   got.wen);
      if (got.fupd  != want.fupd)  flag_mismatch("flags_update", want.fupd,  got.fupd);
      if (got.nzcv  != want.nzcv)  flag_mismatch("new_flags",    want.nzcv,  got.nzcv);
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  a64dp_in_if  in_ch();
  a64dp_out_if out_ch();

  aarch64_dp_register_execute dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  exec_scoreboard sb = new();

  int send_idle_pct = 0;  // chance in a hundred that the sender skips a cycle
  int recv_idle_pct = 0;  // same for the receiver
  int hold_asked    = 0;  // bumped by the stimulus to ask for a long hold-off
  int quiet_cycles  = 0;

  always #10 clk = ~clk;

  // Receiver: random back-pressure, plus a long hold-off whenever one is asked.
  // The hold-off is counted here so the sender keeps offering items meanwhile.
  initial begin : receiver
    int hold_left;
    int holds_taken;
    hold_left   = 0;
    holds_taken = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_taken != hold_asked) begin
        holds_taken++;
        hold_left = HOLD_CYCLES;
      end
      if (rst || hold_left != 0) begin
        out_ch.ready <= 1'b0;
        if (hold_left != 0) hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Monitors on both channels, plus the watchdog on quiet cycles.
  // Everything is sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_item(in_ch.instruction_word, in_ch.first_operand,
                     in_ch.second_operand, in_ch.addend_operand);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(exec_result_t'{out_ch.dest_index, out_ch.result_value,
                                       out_ch.write_enable, out_ch.flags_update,
                                       out_ch.new_flags});
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("aarch64_dp_register_execute regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Encoding of one data-processing (register) instruction. For multiplies
  // the top bit of amt lands on the subtract select.
  function automatic logic [31:0] dp_encoding(logic sf, a64dp_pkg::op_class_t cls,
                                              logic [1:0] opc, a64dp_pkg::shift_t st,
                                              logic [5:0] amt, logic nbit,
                                              logic [4:0] rd);
    logic [31:0] w;
    w                    = '0;
    w[a64dp_pkg::SF_BIT] = sf;
    w[a64dp_pkg::M_BIT]  = (cls == a64dp_pkg::CLS_MUL);
    w[a64dp_pkg::OPR_BIT] = (cls == a64dp_pkg::CLS_ARITH);
    w[30:29]             = opc;
    w[a64dp_pkg::N_BIT]  = nbit;
    w[23:22]             = st;
    w[15:10]             = amt;
    w[4:0]               = rd;
    return w;
  endfunction

  // Operand values biased towards the corners that upset adders and shifters.
  function automatic logic [63:0] rand_operand();
    case ($urandom_range(11))
      0:       return 64'd0;
      1:       return ALL_ONES;
      2:       return MSB64;
      3:       return MAX64;
      4:       return {$urandom(), 32'h8000_0000};
      5:       return {$urandom(), 32'h7FFF_FFFF};
      6:       return {32'd0, 32'($urandom_range(255))};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Offer one item, idling first at the sender's rate; returns at the edge
  // where it was taken. valid is left high for the caller to reuse.
  task automatic present_item(logic [31:0] word, logic [63:0] rn, logic [63:0] rm,
                              logic [63:0] ra);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.instruction_word <= word;
    in_ch.first_operand    <= rn;
    in_ch.second_operand   <= rm;
    in_ch.addend_operand   <= ra;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Sender stands back until every outstanding result has come out. It lets the
  // monitor book the last item taken before it starts waiting.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly well-formed instructions of each class with random content; the
  // rest is the raw random word. Amounts lean towards zero and the edges.
  task automatic random_phase(int count, bit with_hold);
    logic [31:0] word;
    logic [63:0] rn, rm, ra;
    int          pick;
    for (int i = 0; i < count; i++) begin
      word = $urandom();
      pick = $urandom_range(99);
      if (pick < 40) begin
        word[a64dp_pkg::M_BIT]   = 1'b0;
        word[a64dp_pkg::OPR_BIT] = 1'b0;
      end else if (pick < 78) begin
        word[a64dp_pkg::M_BIT]   = 1'b0;
        word[a64dp_pkg::OPR_BIT] = 1'b1;
      end else if (pick < 93) begin
        word[a64dp_pkg::M_BIT]   = 1'b1;
      end
      case ($urandom_range(9))
        0, 1: word[15:10] = 6'd0;
        2:    word[15:10] = 6'd31;
        3:    word[15:10] = 6'd32;
        4:    word[15:10] = 6'd63;
        5:    word[15:10] = 6'd1;
        default: ;
      endcase
      rn = rand_operand();
      rm = rand_operand();
      ra = rand_operand();
      if ($urandom_range(9) == 0) rm = rn;  // equal operands: zero on subtract
      if (with_hold && i == count / 3) hold_asked <= hold_asked + 1;
      present_item(word, rn, rm, ra);
    end
  endtask

  initial begin
    in_ch.valid            <= 1'b0;
    in_ch.instruction_word <= '0;
    in_ch.first_operand    <= '0;
    in_ch.second_operand   <= '0;
    in_ch.addend_operand   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: every operation, flag corners, shifter corners, both widths
    present_item(dp_encoding(1, a64dp_pkg::CLS_LOGIC, a64dp_pkg::LOP_AND, a64dp_pkg::SH_LSL,
                             0, 0, 1), ALL_ONES, ALL_ONES, 0);
    present_item(dp_encoding(1, a64dp_pkg::CLS_LOGIC, a64dp_pkg::LOP_AND, a64dp_pkg::SH_LSR,
                             63, 1, 2), ALL_ONES, MSB64, ALL_ONES);
    // 32-bit with junk in the upper halves
    present_item(dp_encoding(0, a64dp_pkg::CLS_LOGIC, a64dp_pkg::LOP_ORR, a64dp_pkg::SH_ASR,
                             31, 0, 3), 64'hDEAD_BEEF_0000_0000, 64'h1234_5678_8000_0000, 0);
    present_item(dp_encoding(1, a64dp_pkg::CLS_LOGIC, a64dp_pkg::LOP_ORR, a64dp_pkg::SH_ROR,
                             1, 1, 4), 0, 64'd1, 0);
    // amount 33 in 32-bit mode acts as 1
    present_item(dp_encoding(0, a64dp_pkg::CLS_LOGIC, a64dp_pkg::LOP_EOR, a64dp_pkg::SH_LSL,
                             33, 0, 5), ALL_ONES, 64'd1, 0);
    present_item(dp_encoding(1, a64dp_pkg::CLS_LOGIC, a64dp_pkg::LOP_EOR, a64dp_pkg::SH_ASR,
                             32, 1, 6), MSB64, MSB64, 0);
    present_item(dp_encoding(1, a64dp_pkg::CLS_LOGIC, a64dp_pkg::LOP_ANDS, a64dp_pkg::SH_LSL,
                             0, 0, 7), 64'hF0F0_F0F0_F0F0_F0F0, 64'h0F0F_0F0F_0F0F_0F0F, 0);
    present_item(dp_encoding(0, a64dp_pkg::CLS_LOGIC, a64dp_pkg::LOP_ANDS, a64dp_pkg::SH_LSL,
                             0, 1, 8), ALL_ONES, 0, 0);
    // ANDS to register 31: flags still produced, no write
    present_item(dp_encoding(1, a64dp_pkg::CLS_LOGIC, a64dp_pkg::LOP_ANDS, a64dp_pkg::SH_ROR,
                             0, 0, 31), MSB64, ALL_ONES, 0);
    present_item(dp_encoding(1, a64dp_pkg::CLS_ARITH, AOP_ADD, a64dp_pkg::SH_LSL,
                             0, 0, 9), ALL_ONES, 64'd1, 0);
    present_item(dp_encoding(1, a64dp_pkg::CLS_ARITH, AOP_ADDS, a64dp_pkg::SH_ASR,
                             0, 0, 10), ALL_ONES, 64'd1, 0);
    present_item(dp_encoding(0, a64dp_pkg::CLS_ARITH, AOP_ADDS, a64dp_pkg::SH_LSL,
                             0, 0, 11), 64'hFFFF_FFFF_7FFF_FFFF, 64'd1, 0);
    present_item(dp_encoding(1, a64dp_pkg::CLS_ARITH, AOP_ADDS, a64dp_pkg::SH_LSL,
                             0, 0, 12), MAX64, 64'd1, 0);
    present_item(dp_encoding(1, a64dp_pkg::CLS_ARITH, AOP_SUB, a64dp_pkg::SH_LSR,
                             4, 0, 13), 0, 64'h100, 0);
    present_item(dp_encoding(1, a64dp_pkg::CLS_ARITH, AOP_SUBS, a64dp_pkg::SH_LSR,
                             0, 0, 14), 64'h1234, 64'h1234, 0);
    present_item(dp_encoding(0, a64dp_pkg::CLS_ARITH, AOP_SUBS, a64dp_pkg::SH_LSL,
                             0, 0, 15), 0, 64'd1, 0);
    present_item(dp_encoding(1, a64dp_pkg::CLS_ARITH, AOP_SUBS, a64dp_pkg::SH_LSL,
                             0, 0, 16), MSB64, 64'd1, 0);
    // rotate applied on the arithmetic forms too
    present_item(dp_encoding(1, a64dp_pkg::CLS_ARITH, AOP_ADDS, a64dp_pkg::SH_ROR,
                             8, 0, 17), 64'd1, 64'hFF, 0);
    present_item(dp_encoding(0, a64dp_pkg::CLS_ARITH, AOP_SUBS, a64dp_pkg::SH_ROR,
                             31, 0, 18), 64'h0000_0000_8000_0000, 64'h0000_0000_C000_0001, 0);
    present_item(dp_encoding(1, a64dp_pkg::CLS_ARITH, AOP_ADDS, a64dp_pkg::SH_LSL,
                             0, 0, 31), MAX64, MAX64, 0);
    present_item(dp_encoding(1, a64dp_pkg::CLS_MUL, 2'b00, a64dp_pkg::SH_LSL,
                             6'd0, 0, 20), ALL_ONES, ALL_ONES, 64'd5);
    present_item(dp_encoding(1, a64dp_pkg::CLS_MUL, 2'b00, a64dp_pkg::SH_LSL,
                             6'b100000, 0, 21), MAX64, 64'd3, 0);
    present_item(dp_encoding(0, a64dp_pkg::CLS_MUL, 2'b00, a64dp_pkg::SH_LSL,
                             6'd0, 0, 22),
                 64'hFFFF_FFFF_0001_0000, 64'hAAAA_0000_0001_0000, 64'h1234_5678_0000_0001);
    present_item(dp_encoding(0, a64dp_pkg::CLS_MUL, 2'b00, a64dp_pkg::SH_LSL,
                             6'b100000, 0, 23), 64'd7, 64'd9, 0);
    // register fields and unused bits set: must all be ignored
    present_item(dp_encoding(1, a64dp_pkg::CLS_ARITH, AOP_SUBS, a64dp_pkg::SH_LSL,
                             2, 0, 24) | 32'h0E1F_03E0, 64'd100, 64'd25, 0);
    wait_results_drained();

    // sender busy, receiver mostly stalling
    send_idle_pct = 27;
    recv_idle_pct = 75;
    random_phase(PHASE_ITEMS, 1'b0);
    wait_results_drained();

    send_idle_pct = 75;
    recv_idle_pct = 27;
    random_phase(PHASE_ITEMS, 1'b0);
    wait_results_drained();

    // full rate, with one long hold-off that backs the block up to its input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(PHASE_ITEMS, 1'b1);
    wait_results_drained();

    repeat (DRAIN_TAIL) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0)
      $display("aarch64_dp_register_execute regression: pass");
    else
      $display("aarch64_dp_register_execute regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/a64dp_pkg.sv
rtl/a64dp_if.sv
rtl/a64dp_queue.sv
rtl/a64dp_front.sv
rtl/a64dp_back.sv
rtl/aarch64_dp_register_execute.sv
bench/tb_top.sv
